// ===== hdl/pjac_pkg.sv =====
// ----------------------------------------------------------------------------
// pjac_pkg: shared types and constants
// Payload structs, register indexes and divider sizing for the projection unit.
// ----------------------------------------------------------------------------
package pjac_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QBITS     = 33;
  localparam int NUM_W     = 64 + FRAC_BITS;
  localparam int DEN_W     = 64;
  localparam int DIV_LAT   = QBITS + 2;

  typedef enum logic [7:0] {
    REG_FOCAL_X  = 8'd0,
    REG_FOCAL_Y  = 8'd1,
    REG_CENTER_X = 8'd2,
    REG_CENTER_Y = 8'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic signed [31:0] du_by_dx;
    logic signed [31:0] du_by_dz;
    logic signed [31:0] dv_by_dy;
    logic signed [31:0] dv_by_dz;
    logic               point_valid;
    logic               saturated;
  } result_t;

endpackage

// ===== hdl/pinhole_projection_with_jacobian_unit.sv =====
// ----------------------------------------------------------------------------
// pinhole_projection_with_jacobian_unit: pinhole projection and Jacobian
// Projects a camera-frame point to a pixel and gives the projection Jacobian.
//
//   channel  signals                              direction
//   point    start, busy, point                   in
//   result   done, result                         out
//   config   cfg_valid, cfg_ready, cfg_index/data in
//
// One item is taken every cycle; busy is always low.
// Each item passes the input registers, the product registers, the
// bit-per-stage dividers and the result registers.
// Reset clears the valid pipeline and restores the default registers.
// The receiver cannot stall, so the pipeline advances every cycle.
// ----------------------------------------------------------------------------
module pinhole_projection_with_jacobian_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  pjac_pkg::point_t     point,
  output logic                 done,
  output pjac_pkg::result_t    result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int LAT = pjac_pkg::DIV_LAT + 3;
  localparam int F   = pjac_pkg::FRAC_BITS;

  logic [31:0] focal_x, focal_y, center_x, center_y;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x  <= 32'd33554432;
      focal_y  <= 32'd33554432;
      center_x <= 32'd20971520;
      center_y <= 32'd15728640;
    end else if (cfg_valid) begin
      case (cfg_index)
        pjac_pkg::REG_FOCAL_X:  focal_x  <= cfg_data;
        pjac_pkg::REG_FOCAL_Y:  focal_y  <= cfg_data;
        pjac_pkg::REG_CENTER_X: center_x <= cfg_data;
        pjac_pkg::REG_CENTER_Y: center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  logic        v1, v2;
  logic [31:0] mag_x, mag_y;
  logic [30:0] z1;
  logic        nx1, ny1, nx2, ny2, zok1, zok2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    mag_x <= point.point_x[31] ? (~point.point_x + 32'd1) : point.point_x;
    mag_y <= point.point_y[31] ? (~point.point_y + 32'd1) : point.point_y;
    nx1   <= point.point_x[31];
    ny1   <= point.point_y[31];
    z1    <= point.point_z[30:0];
    zok1  <= !point.point_z[31] && (point.point_z != 32'sd0);
  end

  logic [63:0] prod_x, prod_y;
  logic [61:0] zsq;
  logic [30:0] z2;
  logic [31:0] fx2, fy2;

  always_ff @(posedge clk) begin
    prod_x <= 64'(focal_x) * 64'(mag_x);
    prod_y <= 64'(focal_y) * 64'(mag_y);
    zsq    <= 62'(z1) * 62'(z1);
    z2     <= z1;
    fx2    <= focal_x;
    fy2    <= focal_y;
    nx2    <= nx1;
    ny2    <= ny1;
    zok2   <= zok1;
  end

  logic [pjac_pkg::QBITS:0] m_pu, m_lx, m_zx, m_pv, m_ly, m_zy;

  pjac_div u_div_pu (.clk(clk), .num(pjac_pkg::NUM_W'(prod_x)),
                     .den(pjac_pkg::DEN_W'(z2)), .quo(m_pu));
  pjac_div u_div_lx (.clk(clk), .num(pjac_pkg::NUM_W'(fx2) << F),
                     .den(pjac_pkg::DEN_W'(z2)), .quo(m_lx));
  pjac_div u_div_zx (.clk(clk), .num({prod_x, {F{1'b0}}}),
                     .den(pjac_pkg::DEN_W'(zsq)), .quo(m_zx));
  pjac_div u_div_pv (.clk(clk), .num(pjac_pkg::NUM_W'(prod_y)),
                     .den(pjac_pkg::DEN_W'(z2)), .quo(m_pv));
  pjac_div u_div_ly (.clk(clk), .num(pjac_pkg::NUM_W'(fy2) << F),
                     .den(pjac_pkg::DEN_W'(z2)), .quo(m_ly));
  pjac_div u_div_zy (.clk(clk), .num({prod_y, {F{1'b0}}}),
                     .den(pjac_pkg::DEN_W'(zsq)), .quo(m_zy));

  logic [pjac_pkg::DIV_LAT-1:0] dv, dnx, dny, dzok;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else begin
      dv <= {dv[pjac_pkg::DIV_LAT-2:0], v2};
    end
  end

  always_ff @(posedge clk) begin
    dnx  <= {dnx[pjac_pkg::DIV_LAT-2:0], nx2};
    dny  <= {dny[pjac_pkg::DIV_LAT-2:0], ny2};
    dzok <= {dzok[pjac_pkg::DIV_LAT-2:0], zok2};
  end

  function automatic logic [32:0] clamp32(input logic signed [35:0] v);
    logic [32:0] r;
    if (v > $signed(36'h07FFFFFFF)) begin
      r = {1'b1, 32'h7FFFFFFF};
    end else if (v < $signed(36'hF80000000)) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  logic              nx, ny, zok;
  logic signed [35:0] spu, spv, slx, sly, szx, szy;
  logic [32:0]        cpu, cpv, clx, cly, czx, czy;

  always_comb begin
    nx  = dnx[pjac_pkg::DIV_LAT-1];
    ny  = dny[pjac_pkg::DIV_LAT-1];
    zok = dzok[pjac_pkg::DIV_LAT-1];
    spu = (nx ? -$signed({2'b0, m_pu}) : $signed({2'b0, m_pu})) + $signed({4'b0, center_x});
    spv = (ny ? -$signed({2'b0, m_pv}) : $signed({2'b0, m_pv})) + $signed({4'b0, center_y});
    slx = $signed({2'b0, m_lx});
    sly = $signed({2'b0, m_ly});
    szx = nx ? $signed({2'b0, m_zx}) : -$signed({2'b0, m_zx});
    szy = ny ? $signed({2'b0, m_zy}) : -$signed({2'b0, m_zy});
    cpu = clamp32(spu);
    cpv = clamp32(spv);
    clx = clamp32(slx);
    cly = clamp32(sly);
    czx = clamp32(szx);
    czy = clamp32(szy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[pjac_pkg::DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (zok) begin
      result.pixel_u     <= cpu[31:0];
      result.pixel_v     <= cpv[31:0];
      result.du_by_dx    <= clx[31:0];
      result.du_by_dz    <= czx[31:0];
      result.dv_by_dy    <= cly[31:0];
      result.dv_by_dz    <= czy[31:0];
      result.point_valid <= 1'b1;
      result.saturated   <= cpu[32] | cpv[32] | clx[32] | cly[32] | czx[32] | czy[32];
    end else begin
      result <= '0;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done)
    else $error("item did not produce a result at the expected latency");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.point_valid) |-> (result.saturated == 1'b0 &&
      result.pixel_u == 32'sd0 && result.du_by_dx == 32'sd0))
    else $error("invalid point result is not cleared");

endmodule

// ===== hdl/pjac_div.sv =====
// ----------------------------------------------------------------------------
// pjac_div: pipelined rounding divider
// Restoring division, one quotient bit per stage, rounded to nearest with a
// capped magnitude when the quotient does not fit.
// ----------------------------------------------------------------------------
module pjac_div (
  input  logic                           clk,
  input  logic [pjac_pkg::NUM_W-1:0]     num,
  input  logic [pjac_pkg::DEN_W-1:0]     den,
  output logic [pjac_pkg::QBITS:0]       quo
);

  localparam int K  = pjac_pkg::QBITS;
  localparam int DW = pjac_pkg::DEN_W;

  logic [DW-1:0] rem  [K+1];
  logic [DW-1:0] dd   [K+1];
  logic [K-1:0]  nlo  [K+1];
  logic [K-1:0]  qq   [K+1];
  logic          big  [K+1];

  always_ff @(posedge clk) begin
    big[0] <= (num >> K) >= pjac_pkg::NUM_W'(den);
    rem[0] <= DW'(num >> K);
    nlo[0] <= num[K-1:0];
    dd[0]  <= den;
    qq[0]  <= '0;
  end

  for (genvar i = 1; i <= K; i++) begin : g_stage
    logic [DW:0] t;
    logic        ge;
    always_comb begin
      t  = {rem[i-1], nlo[i-1][K-1]};
      ge = t >= {1'b0, dd[i-1]};
    end
    always_ff @(posedge clk) begin
      rem[i] <= ge ? DW'(t - {1'b0, dd[i-1]}) : DW'(t);
      nlo[i] <= nlo[i-1] << 1;
      qq[i]  <= {qq[i-1][K-2:0], ge};
      dd[i]  <= dd[i-1];
      big[i] <= big[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (big[K]) begin
      quo <= {1'b1, {K{1'b0}}};
    end else begin
      quo <= {1'b0, qq[K]} + (K+1)'({rem[K], 1'b0} >= {1'b0, dd[K]});
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: pinhole projection and Jacobian unit
// Drives camera-frame points through the command port and checks every result
// against a fixed-point predictor of the projection, under several register
// settings, with random gaps on the sender side.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = pjac_pkg::DIV_LAT + 3;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  pjac_pkg::point_t point = '0;
  logic done;
  pjac_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pinhole_projection_with_jacobian_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [31:0] fx, fy, cx, cy;
  pjac_pkg::point_t pending_points[$];
  pjac_pkg::result_t expected_results[$];
  int send_idle_pct = 0;
  int errors = 0;
  longint cycles = 0;

  function automatic logic [63:0] round_quotient(logic [127:0] num, logic [63:0] den);
    logic [127:0] q;
    logic [127:0] r;
    if (den == 0) return 64'h100_0000_0000;
    q = num / den;
    r = num % den;
    if (q >= 128'h100_0000_0000) return 64'h100_0000_0000;
    if ({r, 1'b0} >= {65'd0, den}) q = q + 1;
    return q[63:0];
  endfunction

  function automatic logic [31:0] clip32(logic signed [65:0] v, ref logic sat);
    if (v > 66'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -66'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic void project_axis(input logic [31:0] f, input logic [31:0] c,
                                       input logic signed [31:0] p,
                                       input logic [63:0] z,
                                       ref logic sat, output logic [31:0] pix,
                                       output logic [31:0] dlin,
                                       output logic [31:0] dz);
    logic neg;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] m;
    logic signed [65:0] s;
    neg = p < 0;
    mag = neg ? -{{32{p[31]}}, p} : {32'd0, p};
    prod = {32'd0, f} * mag;
    m = round_quotient({64'd0, prod}, z);
    s = neg ? -$signed({2'b0, m}) : $signed({2'b0, m});
    pix = clip32(s + $signed({34'd0, c}), sat);
    m = round_quotient({64'd0, {32'd0, f} << pjac_pkg::FRAC_BITS}, z);
    dlin = clip32($signed({2'b0, m}), sat);
    m = round_quotient({64'd0, prod} << pjac_pkg::FRAC_BITS, z * z);
    s = neg ? $signed({2'b0, m}) : -$signed({2'b0, m});
    dz = clip32(s, sat);
  endfunction

  function automatic pjac_pkg::result_t project_point(pjac_pkg::point_t pt);
    pjac_pkg::result_t r;
    logic sat;
    r = '0;
    sat = 1'b0;
    if (pt.point_z <= 0) return r;
    project_axis(fx, cx, pt.point_x, {32'd0, pt.point_z}, sat,
                 r.pixel_u, r.du_by_dx, r.du_by_dz);
    project_axis(fy, cy, pt.point_y, {32'd0, pt.point_z}, sat,
                 r.pixel_v, r.dv_by_dy, r.dv_by_dz);
    r.point_valid = 1'b1;
    r.saturated = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst && start && !busy) void'(pending_points.pop_front());
    if (!rst && pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      start <= 1'b1;
      point <= pending_points[0];
    end else begin
      start <= 1'b0;
      point <= {$urandom, $urandom, $urandom};
    end
  end

  always @(posedge clk) begin
    pjac_pkg::result_t exp_r;
    if (!rst && start && !busy) expected_results.push_back(project_point(point));
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result.pixel_u !== exp_r.pixel_u) begin
          $error("pixel_u exp %h got %h", exp_r.pixel_u, result.pixel_u); errors++;
        end
        if (result.pixel_v !== exp_r.pixel_v) begin
          $error("pixel_v exp %h got %h", exp_r.pixel_v, result.pixel_v); errors++;
        end
        if (result.du_by_dx !== exp_r.du_by_dx) begin
          $error("du_by_dx exp %h got %h", exp_r.du_by_dx, result.du_by_dx); errors++;
        end
        if (result.du_by_dz !== exp_r.du_by_dz) begin
          $error("du_by_dz exp %h got %h", exp_r.du_by_dz, result.du_by_dz); errors++;
        end
        if (result.dv_by_dy !== exp_r.dv_by_dy) begin
          $error("dv_by_dy exp %h got %h", exp_r.dv_by_dy, result.dv_by_dy); errors++;
        end
        if (result.dv_by_dz !== exp_r.dv_by_dz) begin
          $error("dv_by_dz exp %h got %h", exp_r.dv_by_dz, result.dv_by_dz); errors++;
        end
        if (result.point_valid !== exp_r.point_valid) begin
          $error("point_valid exp %b got %b", exp_r.point_valid, result.point_valid);
          errors++;
        end
        if (result.saturated !== exp_r.saturated) begin
          $error("saturated exp %b got %b", exp_r.saturated, result.saturated); errors++;
        end
      end
    end
  end

  task automatic write_reg(pjac_pkg::reg_index_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      pjac_pkg::REG_FOCAL_X: fx = value;
      pjac_pkg::REG_FOCAL_Y: fy = value;
      pjac_pkg::REG_CENTER_X: cx = value;
      pjac_pkg::REG_CENTER_Y: cy = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      2: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
      3: return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
      default: return $urandom_range(32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_depth();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(32'h0000_0100, 1);
      2: return 32'h8000_0000 | $urandom;
      3: return 32'h7fff_0000 | $urandom_range(16'hffff);
      default: return $urandom_range(32'h0080_0000, 32'h0000_1000);
    endcase
  endfunction

  task automatic random_points(int n);
    repeat (n) pending_points.push_back({rand_coord(), rand_coord(), rand_depth()});
  endtask

  initial begin
    fx = 32'd33554432;
    fy = 32'd33554432;
    cx = 32'd20971520;
    cy = 32'd15728640;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    pending_points.push_back({32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000});
    pending_points.push_back({32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0001});
    pending_points.push_back({32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff});
    pending_points.push_back({32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000});
    pending_points.push_back({32'sh0001_0000, 32'sh0002_0000, 32'sh8000_0000});
    pending_points.push_back({32'sh0001_0000, 32'sh0002_0000, 32'shffff_ffff});
    pending_points.push_back({32'shffff_0000, 32'sh0000_8000, 32'sh0002_0000});
    pending_points.push_back({32'sh0000_0001, 32'shffff_ffff, 32'sh0000_0002});
    pending_points.push_back({32'sh0000_0003, 32'shffff_fffd, 32'sh0000_0002});
    pending_points.push_back({32'sh0000_0000, 32'sh0000_0000, 32'sh7fff_ffff});
    drain();

    write_reg(pjac_pkg::REG_FOCAL_X, 32'hffff_ffff);
    write_reg(pjac_pkg::REG_FOCAL_Y, 32'd1);
    write_reg(pjac_pkg::REG_CENTER_X, 32'hffff_ffff);
    write_reg(pjac_pkg::REG_CENTER_Y, 32'd0);
    pending_points.push_back({32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000});
    pending_points.push_back({32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0001});
    pending_points.push_back({32'shffff_0000, 32'shffff_0000, 32'sh0100_0000});
    drain();
    write_reg(pjac_pkg::REG_FOCAL_X, 32'd0);
    pending_points.push_back({32'sh0001_0000, 32'sh0003_0000, 32'sh0001_0000});
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      send_idle_pct = (phase < 2) ? 22 : (phase < 4) ? 58 : 0;
      write_reg(pjac_pkg::REG_FOCAL_X,
                (phase == 1) ? 32'hffff_ffff : $urandom_range(32'h0400_0000, 1));
      write_reg(pjac_pkg::REG_FOCAL_Y, (phase == 3) ? 32'd1 : $urandom);
      write_reg(pjac_pkg::REG_CENTER_X,
                (phase == 5) ? 32'd0 : $urandom_range(32'h0400_0000));
      write_reg(pjac_pkg::REG_CENTER_Y, (phase == 2) ? 32'hffff_ffff : $urandom);
      random_points(310);
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
